// ===== hdl/huv_pkg.sv =====
// types, constants and character tables for the https url validator
`timescale 1ns / 1ps

package huv_pkg;

    localparam int MAX_URL_BYTES = 2048;
    // byte count saturates one above the limit
    localparam int CNT_W = $clog2(MAX_URL_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_URL_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_URL_BYTES);
    localparam logic [CNT_W-1:0] PREFIX_LEN = CNT_W'(8);

    localparam logic [7:0] HOST_SAT = 8'd254;
    localparam logic [7:0] HOST_MAX = 8'd253;
    localparam logic [6:0] LABEL_SAT = 7'd64;
    localparam logic [6:0] LABEL_MAX = 7'd63;
    localparam logic [7:0] LOCALHOST_LEN = 8'd9;
    localparam logic [7:0] SUFFIX_LEN = 8'd6;
    localparam logic [2:0] PORT_DONE = 3'd4;

    localparam logic [7:0] CH_DOT = 8'h2e;
    localparam logic [7:0] CH_DASH = 8'h2d;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_QUEST = 8'h3f;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_AT = 8'h40;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7f;

    // ".local" with the oldest byte in the lowest lane
    localparam logic [5:0][7:0] SUFFIX_LOCAL = {8'h6c, 8'h61, 8'h63, 8'h6f, 8'h6c, 8'h2e};

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_HOST   = 2'd1,
        PH_PORT   = 2'd2,
        PH_REST   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        phase_t           phase;
        logic             rejected;
        logic [7:0]       host_length;
        logic [6:0]       label_length;
        logic             label_started;
        logic [7:0]       prev_host_byte;
        logic             host_all_numeric;
        logic [2:0]       port_index;
        logic             localhost_match;
        logic [5:0][7:0]  suffix_window;
    } parse_state_t;

    function automatic parse_state_t state_init();
        parse_state_t s;
        s.byte_count       = '0;
        s.phase            = PH_PREFIX;
        s.rejected         = 1'b0;
        s.host_length      = '0;
        s.label_length     = '0;
        s.label_started    = 1'b0;
        s.prev_host_byte   = '0;
        s.host_all_numeric = 1'b1;
        s.port_index       = '0;
        s.localhost_match  = 1'b1;
        s.suffix_window    = '0;
        return s;
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0: c = 8'h68; // h
            3'd1: c = 8'h74; // t
            3'd2: c = 8'h74; // t
            3'd3: c = 8'h70; // p
            3'd4: c = 8'h73; // s
            3'd5: c = 8'h3a; // :
            3'd6: c = 8'h2f; // /
            3'd7: c = 8'h2f; // /
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] port_char(input logic [1:0] i);
        logic [7:0] c;
        case (i)
            2'd0: c = 8'h3a; // :
            2'd1: c = 8'h34; // 4
            2'd2: c = 8'h34; // 4
            2'd3: c = 8'h33; // 3
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] localhost_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0: c = 8'h6c; // l
            4'd1: c = 8'h6f; // o
            4'd2: c = 8'h63; // c
            4'd3: c = 8'h61; // a
            4'd4: c = 8'h6c; // l
            4'd5: c = 8'h68; // h
            4'd6: c = 8'h6f; // o
            4'd7: c = 8'h73; // s
            4'd8: c = 8'h74; // t
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // reject bit for a host that ends with the given state
    function automatic logic host_end_bad(input parse_state_t s);
        return (s.host_length == 8'd0) || !s.label_started
            || (s.prev_host_byte == CH_DASH)
            || (s.host_length > HOST_MAX) || s.host_all_numeric
            || (s.localhost_match && s.host_length == LOCALHOST_LEN)
            || (s.host_length > SUFFIX_LEN && s.suffix_window == SUFFIX_LOCAL);
    endfunction

endpackage

// ===== hdl/https_url_validator.sv =====
// top level of the https url validator
`timescale 1ns / 1ps

// Checks an https URL that streams in one byte per beat, with tlast on its final
// byte, and gives one verdict beat per URL: bit 0 of m_axis_tdata is 1 when the URL
// passed every rule. A byte is taken every cycle unless stalled; the parser state
// register is updated by one short step of logic per byte, and the verdict appears
// in the result register in the cycle after the last byte is accepted. The input
// stalls only while a verdict sits in the result register and downstream holds
// tready low. All parser state returns to its reset value after each last byte.

module https_url_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] url_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] url_valid, [7:1] zero
);
    import huv_pkg::*;

    parse_state_t state_reg, state_next, step_next;
    logic         step_valid;
    logic         in_beat;
    logic         slot_free;
    logic         verdict_bit;

    assign s_axis_tready = slot_free;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    huv_step u_step (
        .cur       (state_reg),
        .url_byte  (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .nxt       (step_next),
        .url_valid (step_valid)
    );

    assign state_next = in_beat ? step_next : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= state_init();
        end else begin
            state_reg <= state_next;
        end
    end

    huv_out_reg u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (in_beat && s_axis_tlast),
        .url_valid        (step_valid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tdata_bit (verdict_bit),
        .slot_free        (slot_free)
    );

    assign m_axis_tdata = {7'd0, verdict_bit};

    // a new verdict only follows a last beat
    a_verdict_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("verdict without a last beat");

    // a pending verdict blocks the input
    a_stall_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while verdict pending");

    // parser state clears after each url
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast)
            |=> (state_reg.byte_count == '0 && state_reg.phase == PH_PREFIX
                 && !state_reg.rejected))
        else $error("parser state not cleared after last beat");

endmodule

// ===== hdl/huv_step.sv =====
// per-byte parse step: next parser state and verdict for one beat
`timescale 1ns / 1ps

module huv_step (
    input  huv_pkg::parse_state_t cur,
    input  logic [7:0]            url_byte,
    input  logic                  last_byte,
    output huv_pkg::parse_state_t nxt,
    output logic                  url_valid
);
    import huv_pkg::*;

    parse_state_t s;
    logic [7:0]   fb;
    logic         alnum;
    logic         bad;

    always_comb begin
        s     = cur;
        fb    = fold(url_byte);
        alnum = is_digit(url_byte) || (fb >= 8'h61 && fb <= 8'h7a);

        if (cur.byte_count != CNT_SAT) begin
            s.byte_count = cur.byte_count + 1'b1;
        end
        if (url_byte < CH_SPACE || url_byte == CH_DEL || url_byte == CH_HASH) begin
            s.rejected = 1'b1;
        end

        case (cur.phase)
            PH_PREFIX: begin
                if (cur.byte_count >= PREFIX_LEN
                        || url_byte != prefix_char(cur.byte_count[2:0])) begin
                    s.rejected = 1'b1;
                end
                if (cur.byte_count >= PREFIX_LEN - 1'b1) begin
                    s.phase = PH_HOST;
                end
            end
            PH_HOST: begin
                if (url_byte == CH_SLASH || url_byte == CH_QUEST) begin
                    if (host_end_bad(cur)) begin
                        s.rejected = 1'b1;
                    end
                    s.phase = PH_REST;
                end else if (url_byte == CH_COLON) begin
                    if (host_end_bad(cur)) begin
                        s.rejected = 1'b1;
                    end
                    s.port_index = 3'd1;
                    s.phase      = PH_PORT;
                end else if (url_byte == CH_AT) begin
                    s.rejected = 1'b1;
                end else if (url_byte != CH_HASH) begin
                    if (url_byte == CH_DOT) begin
                        if (cur.host_length == 8'd0 || !cur.label_started
                                || cur.prev_host_byte == CH_DASH) begin
                            s.rejected = 1'b1;
                        end
                        s.label_started = 1'b0;
                        s.label_length  = '0;
                    end else if (alnum || url_byte == CH_DASH) begin
                        if (!cur.label_started && url_byte == CH_DASH) begin
                            s.rejected = 1'b1;
                        end
                        s.label_started = 1'b1;
                        if (cur.label_length < LABEL_SAT) begin
                            s.label_length = cur.label_length + 1'b1;
                        end
                        if (s.label_length > LABEL_MAX) begin
                            s.rejected = 1'b1;
                        end
                        if (!is_digit(url_byte)) begin
                            s.host_all_numeric = 1'b0;
                        end
                    end else begin
                        s.rejected = 1'b1;
                    end
                    if (cur.host_length >= LOCALHOST_LEN
                            || fb != localhost_char(cur.host_length[3:0])) begin
                        s.localhost_match = 1'b0;
                    end
                    s.suffix_window = {fb, cur.suffix_window[5:1]};
                    if (cur.host_length < HOST_SAT) begin
                        s.host_length = cur.host_length + 1'b1;
                    end
                    s.prev_host_byte = url_byte;
                end
            end
            PH_PORT: begin
                if (url_byte == CH_SLASH || url_byte == CH_QUEST) begin
                    if (cur.port_index != PORT_DONE) begin
                        s.rejected = 1'b1;
                    end
                    s.phase = PH_REST;
                end else if (cur.port_index < PORT_DONE
                        && url_byte == port_char(cur.port_index[1:0])) begin
                    s.port_index = cur.port_index + 1'b1;
                end else begin
                    s.rejected = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // end of url checks
        bad = s.rejected || s.byte_count > CNT_MAX || s.byte_count <= PREFIX_LEN;
        case (s.phase)
            PH_PREFIX: bad = 1'b1;
            PH_HOST:   bad = bad || host_end_bad(s);
            PH_PORT:   bad = bad || (s.port_index != PORT_DONE);
            default:   bad = bad;
        endcase
        url_valid = !bad;

        nxt = last_byte ? state_init() : s;
    end

endmodule

// ===== hdl/huv_out_reg.sv =====
// result register for the verdict beat
`timescale 1ns / 1ps

module huv_out_reg (
    input  logic aclk,
    input  logic aresetn,
    input  logic load,
    input  logic url_valid,
    input  logic m_axis_tready,
    output logic m_axis_tvalid,
    output logic m_axis_tdata_bit,
    output logic slot_free
);
    logic valid_reg, valid_next;
    logic data_reg, data_next;

    // free when empty or being drained this cycle
    assign slot_free = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = url_valid;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_axis_tvalid    = valid_reg;
    assign m_axis_tdata_bit = data_reg;

endmodule
